// File: rtl/hmsa_pkg.sv
package hmsa_pkg;

  // Field widths of the streaming interface
  localparam int SCORE_W     = 16;
  localparam int CLASS_W     = 2;
  localparam int PROB_W      = 16;
  localparam int PROB_OUTS   = 3;

  // Internal arithmetic widths
  localparam int DIFF_W      = SCORE_W - 1;      // non-negative maxima and gaps
  localparam int EXP_W       = 17;               // exp value, 0..65536
  localparam int PROD_W      = 2 * EXP_W;        // table product
  localparam int FRAC_BITS   = 4;                // fraction bits kept for exp
  localparam int FRAC_LSB    = 4;                // fraction bits dropped
  localparam int INT_LSB     = FRAC_LSB + FRAC_BITS;
  localparam int EXP_INT_LEN = 12;
  localparam int QUO_W       = EXP_W;            // quotient 0..65536
  localparam int NUM_W       = EXP_W + PROB_W;   // dividend e*2^16 + S/2

  localparam int CLASS_COUNT_DEF = 3;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [CLASS_W-1:0]        class_index;
    logic                      frame_end;
  } hmsa_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] best_class;
    logic [PROB_W-1:0]  confidence;
    logic [PROB_W-1:0]  prob_class0;
    logic [PROB_W-1:0]  prob_class1;
    logic [PROB_W-1:0]  prob_class2;
  } hmsa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_EXP,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_OUT
  } hmsa_state_t;

  // round(65536 * exp(-i)), i = 0..11
  function automatic logic [EXP_W-1:0] exp_int_lut(input logic [3:0] i);
    logic [EXP_W-1:0] v;
    case (i)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(65536 * exp(-k/16)), k = 0..15
  function automatic logic [EXP_W-1:0] exp_frac_lut(input logic [FRAC_BITS-1:0] k);
    logic [EXP_W-1:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/hmsa_exp.sv
module hmsa_exp
  import hmsa_pkg::*;
(
  input  logic              clk,
  input  logic [DIFF_W-1:0] gap,
  output logic [EXP_W-1:0]  exp_val
);

  logic [DIFF_W-INT_LSB-1:0] int_part;
  logic [FRAC_BITS-1:0]      frac_part;
  logic                      far_nxt;
  logic [PROD_W-1:0]         prod_nxt;
  logic                      far_r;
  logic [PROD_W-1:0]         prod_r;
  logic [PROD_W-1:0]         rounded;

  assign int_part  = gap[DIFF_W-1:INT_LSB];
  assign frac_part = gap[INT_LSB-1:FRAC_LSB];
  assign far_nxt   = int_part >= (DIFF_W-INT_LSB)'(EXP_INT_LEN);
  assign prod_nxt  = {{EXP_W{1'b0}}, exp_int_lut(int_part[3:0])} *
                     {{EXP_W{1'b0}}, exp_frac_lut(frac_part)};

  // register the product before rounding
  always_ff @(posedge clk) begin
    far_r  <= far_nxt;
    prod_r <= prod_nxt;
  end

  assign rounded = prod_r + PROD_W'(1 << (PROB_W - 1));
  assign exp_val = far_r ? '0 : rounded[PROB_W +: EXP_W];

endmodule

// File: rtl/hmsa_div.sv
module hmsa_div
  import hmsa_pkg::*;
#(
  parameter int DEN_W = EXP_W + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int STEP_W = $clog2(QUO_W);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;

  assign shifted = {rem_r, quo_r[QUO_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  // restoring division, one quotient bit a cycle; dividend low bits shift
  // out of quo_r as quotient bits shift in
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = DEN_W'(num[NUM_W-1:QUO_W]);
      quo_nxt  = num[QUO_W-1:0];
      den_nxt  = den;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DEN_W]) begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DEN_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/heatmap_max_softmax_argmax_unit.sv
// Per-class global max pooling with softmax and argmax over a streamed heatmap.
// Scores beat in one per cycle while the sequencer is idle, each tagged with
// its class; a running maximum per class starts at zero, so a class with only
// negative scores keeps zero, and a class index at or above CLASS_COUNT is
// ignored. A beat that carries frame_end folds its own score in first and then
// starts the softmax sequencer, which holds in_stall high until the result has
// been loaded into the output register: one compare pass over the maxima, one
// table exp per class through a registered multiplier, and one restoring divide
// per class on a shared 17-step divider. Probabilities are Q0.16 rounded to
// nearest and saturated at 65535; the argmax breaks ties toward the lower
// class. The result waits in the output register under out_stall, and score
// beats that do not end a frame keep flowing meanwhile. The maxima clear once
// their exp values are taken.
module heatmap_max_softmax_argmax_unit
  import hmsa_pkg::*;
#(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hmsa_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output hmsa_out_t out_data
);

  localparam int CNT_W = $clog2(CLASS_COUNT);
  localparam int SUM_W = EXP_W + $clog2(CLASS_COUNT);

  hmsa_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIFF_W-1:0] max_r [CLASS_COUNT];
  logic [DIFF_W-1:0] max_nxt [CLASS_COUNT];
  logic [DIFF_W-1:0] peak_r, peak_nxt;
  logic [EXP_W-1:0]  e_r [CLASS_COUNT];
  logic [PROB_W-1:0] p_r [CLASS_COUNT];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  best_r, best_nxt;
  logic [PROB_W-1:0] best_p_r, best_p_nxt;
  logic              out_valid_r, out_valid_nxt;
  hmsa_out_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic              last_cls;
  logic              out_free;
  logic [DIFF_W-1:0] gap;
  logic [EXP_W-1:0]  exp_val;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_num;
  logic [QUO_W-1:0]  quotient;
  logic [PROB_W-1:0] prob_sat;
  logic              score_pos;
  logic [DIFF_W-1:0] score_mag;
  logic [PROB_W-1:0] pc0, pc1, pc2;

  assign in_fire   = in_valid && !in_stall;
  assign last_cls  = cnt_r == CNT_W'(CLASS_COUNT - 1);
  assign out_free  = !out_valid_r || !out_stall;
  assign score_pos = !in_data.score[SCORE_W-1];
  assign score_mag = in_data.score[DIFF_W-1:0];
  assign gap       = peak_r - max_r[cnt_r];
  assign div_num   = {e_r[cnt_r], {PROB_W{1'b0}}} + NUM_W'(sum_r >> 1);
  assign prob_sat  = quotient[QUO_W-1] ? {PROB_W{1'b1}} : quotient[PROB_W-1:0];

  hmsa_exp u_exp (
    .clk     (clk),
    .gap     (gap),
    .exp_val (exp_val)
  );

  hmsa_div #(
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (sum_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.frame_end) state_nxt = ST_MAX;
      end
      ST_MAX: begin
        if (last_cls) state_nxt = ST_EXP;
      end
      ST_EXP:      state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = last_cls ? ST_DIV_LOAD : ST_EXP;
      end
      ST_DIV_LOAD: state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (div_done) state_nxt = last_cls ? ST_OUT : ST_DIV_LOAD;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // handshake and unit controls
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE:     in_stall  = 1'b0;
      ST_DIV_LOAD: div_start = 1'b1;
      default: begin
        in_stall  = 1'b1;
        div_start = 1'b0;
      end
    endcase
  end

  // output fields; classes that do not exist read zero
  always_comb begin
    pc0 = '0;
    pc1 = '0;
    pc2 = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (c == 0) pc0 = p_r[c];
      else if (c == 1) pc1 = p_r[c];
      else if (c == 2) pc2 = p_r[c];
    end
  end

  // datapath registers
  always_comb begin
    cnt_nxt       = cnt_r;
    peak_nxt      = peak_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    best_p_nxt    = best_p_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int c = 0; c < CLASS_COUNT; c++) max_nxt[c] = max_r[c];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          for (int c = 0; c < CLASS_COUNT; c++) begin
            if (32'(in_data.class_index) == c && score_pos && score_mag > max_r[c]) begin
              max_nxt[c] = score_mag;
            end
          end
          cnt_nxt    = '0;
          peak_nxt   = '0;
          sum_nxt    = '0;
          best_nxt   = '0;
          best_p_nxt = '0;
        end
      end
      ST_MAX: begin
        if (max_r[cnt_r] > peak_r) peak_nxt = max_r[cnt_r];
        cnt_nxt = last_cls ? '0 : cnt_r + 1'b1;
      end
      ST_ACC: begin
        sum_nxt = sum_r + SUM_W'(exp_val);
        cnt_nxt = last_cls ? '0 : cnt_r + 1'b1;
        // maxima are no longer needed once the last exp is taken
        if (last_cls) begin
          for (int c = 0; c < CLASS_COUNT; c++) max_nxt[c] = '0;
        end
      end
      ST_DIV_RUN: begin
        if (div_done) begin
          if (prob_sat > best_p_r) begin
            best_nxt   = cnt_r;
            best_p_nxt = prob_sat;
          end
          cnt_nxt = last_cls ? '0 : cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.best_class  = CLASS_W'(best_r);
          out_data_nxt.confidence  = best_p_r;
          out_data_nxt.prob_class0 = pc0;
          out_data_nxt.prob_class1 = pc1;
          out_data_nxt.prob_class2 = pc2;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int c = 0; c < CLASS_COUNT; c++) max_r[c] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      for (int c = 0; c < CLASS_COUNT; c++) max_r[c] <= max_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    peak_r     <= peak_nxt;
    sum_r      <= sum_nxt;
    best_r     <= best_nxt;
    best_p_r   <= best_p_nxt;
    out_data_r <= out_data_nxt;
    // hold per-class exp values and probabilities at the sequencer's slot
    if (state_r == ST_ACC) e_r[cnt_r] <= exp_val;
    if (state_r == ST_DIV_RUN && div_done) p_r[cnt_r] <= prob_sat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import hmsa_pkg::*;

  localparam int N_CLASSES   = 3;
  localparam int RAND_BEATS  = 600;
  localparam int IDLE_PCT    = 32;
  localparam int DRAIN_WAIT  = 100;
  localparam int STUCK_LIMIT = 4000;  // cycles with no beat on either side

  // round(65536*exp(-i)) for whole units, round(65536*exp(-k/16)) for sixteenths
  localparam int unsigned EXP_WHOLE [12] = '{
    65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
  };
  localparam int unsigned EXP_PART [16] = '{
    65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
    39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664
  };

  localparam logic [PROB_W-1:0] THIRD = 16'd21845;  // softmax of three equal maxima

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hmsa_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hmsa_out_t out_data;

  always #10 clk = ~clk;

  heatmap_max_softmax_argmax_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Directed beats. Where 'typed' is set, 'res' is the hand-derived result for a
  // frame-end beat; everything else goes through the softmax predictor.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [CLASS_W-1:0]        cls;
    logic                      fe;
    logic                      typed;
    hmsa_out_t                 res;
  } dir_row_t;

  localparam int N_DIR = 23;
  dir_row_t dir_rows [N_DIR] = '{
    // all maxima still zero after reset: flat distribution, tie goes to class 0
    '{16'sd0,      2'd0, 1'b1, 1'b1, '{2'd0, THIRD, THIRD, THIRD, THIRD}},
    // full-scale positive on class 1, full-scale negative ignored by the clamp
    '{16'sd32767,  2'd1, 1'b0, 1'b0, '0},
    '{-16'sd32768, 2'd0, 1'b1, 1'b1, '{2'd1, 16'd65535, 16'd0, 16'd65535, 16'd0}},
    // class index out of range: score dropped, frame end still fires
    '{16'sd32767,  2'd3, 1'b0, 1'b0, '0},
    '{16'sd100,    2'd3, 1'b1, 1'b1, '{2'd0, THIRD, THIRD, THIRD, THIRD}},
    // only negative scores: maxima stay at zero
    '{-16'sd1,     2'd2, 1'b0, 1'b0, '0},
    '{-16'sd32768, 2'd2, 1'b1, 1'b1, '{2'd0, THIRD, THIRD, THIRD, THIRD}},
    // back-to-back frame ends, the second owning the whole mass
    '{16'sd32767,  2'd2, 1'b1, 1'b1, '{2'd2, 16'd65535, 16'd0, 16'd0, 16'd65535}},
    // tie between classes 1 and 2
    '{16'sd256,    2'd1, 1'b0, 1'b0, '0},
    '{16'sd256,    2'd2, 1'b1, 1'b0, '0},
    // running max must keep the larger of two scores
    '{16'sd300,    2'd0, 1'b0, 1'b0, '0},
    '{16'sd200,    2'd0, 1'b0, 1'b0, '0},
    '{16'sd512,    2'd1, 1'b0, 1'b0, '0},
    '{16'sd768,    2'd2, 1'b0, 1'b0, '0},
    '{16'sd128,    2'd1, 1'b1, 1'b0, '0},
    // tie between classes 0 and 1 at the top
    '{16'sd1000,   2'd0, 1'b0, 1'b0, '0},
    '{16'sd1000,   2'd1, 1'b1, 1'b0, '0},
    // last whole step of the table, then past the table end
    '{16'sd2816,   2'd0, 1'b1, 1'b0, '0},
    '{16'sd3071,   2'd1, 1'b1, 1'b0, '0},
    '{16'sd3072,   2'd2, 1'b1, 1'b1, '{2'd2, 16'd65535, 16'd0, 16'd0, 16'd65535}},
    // finest step that the dropped fraction bits still see
    '{16'sd16,     2'd0, 1'b0, 1'b0, '0},
    '{16'sd15,     2'd1, 1'b0, 1'b0, '0},
    '{16'sd0,      2'd2, 1'b1, 1'b0, '0}
  };

  // Predictor state
  logic signed [SCORE_W-1:0] class_peak [N_CLASSES];
  hmsa_out_t                 frame_q [$];

  // Attributes of the beat currently on the bus
  logic      row_typed = 1'b0;
  hmsa_out_t row_result = '0;

  logic idle_on = 1'b1;
  int   errors = 0;
  int   beats_in = 0;
  int   frames_checked = 0;
  int   stuck_cycles = 0;

  initial begin
    for (int c = 0; c < N_CLASSES; c++) class_peak[c] = '0;
  end

  function automatic logic [EXP_W-1:0] exp_of_gap(logic [DIFF_W-1:0] gap);
    logic [6:0]        whole;
    logic [3:0]        part;
    longint unsigned   prod;
    whole = gap[DIFF_W-1:8];
    part  = gap[7:4];
    if (whole >= 12) return '0;
    prod = 64'(EXP_WHOLE[whole]) * 64'(EXP_PART[part]) + 64'd32768;
    return EXP_W'(prod >> 16);
  endfunction

  // Softmax over the pooled maxima, argmax with ties toward the lower class
  function automatic hmsa_out_t pool_result();
    logic signed [SCORE_W-1:0] top;
    logic [EXP_W-1:0]          e [N_CLASSES];
    logic [PROB_W-1:0]         p [N_CLASSES];
    longint unsigned           total;
    longint unsigned           q;
    int                        best;
    hmsa_out_t                 r;
    top = class_peak[0];
    for (int c = 1; c < N_CLASSES; c++)
      if (class_peak[c] > top) top = class_peak[c];
    total = 0;
    for (int c = 0; c < N_CLASSES; c++) begin
      e[c] = exp_of_gap(DIFF_W'(top - class_peak[c]));
      total += 64'(e[c]);
    end
    for (int c = 0; c < N_CLASSES; c++) begin
      q = (64'(e[c]) * 64'd65536 + total / 2) / total;
      p[c] = (q > 64'd65535) ? 16'hFFFF : PROB_W'(q);
    end
    best = 0;
    for (int c = 1; c < N_CLASSES; c++)
      if (p[c] > p[best]) best = c;
    r.best_class  = CLASS_W'(best);
    r.confidence  = p[best];
    r.prob_class0 = p[0];
    r.prob_class1 = p[1];
    r.prob_class2 = p[2];
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Input side: fold each accepted score into the maxima; on frame end queue the
  // expected result and clear the maxima.
  always @(posedge clk) begin : score_mon
    hmsa_in_t  b;
    hmsa_out_t r;
    if (rst_n && in_valid && !in_stall) begin
      b = in_data;
      beats_in++;
      if (b.class_index < N_CLASSES && b.score > class_peak[b.class_index])
        class_peak[b.class_index] = b.score;
      if (b.frame_end) begin
        r = pool_result();
        frame_q.insert(frame_q.size(), row_typed ? row_result : r);
        for (int c = 0; c < N_CLASSES; c++) class_peak[c] = '0;
      end
    end
  end

  // Output side: compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_mon
    hmsa_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = frame_q[0];
        frame_q.delete(0);
        frames_checked++;
        if (out_data.best_class != want.best_class)
          report_mismatch("best_class", out_data.best_class, want.best_class);
        if (out_data.confidence != want.confidence)
          report_mismatch("confidence", out_data.confidence, want.confidence);
        if (out_data.prob_class0 != want.prob_class0)
          report_mismatch("prob_class0", out_data.prob_class0, want.prob_class0);
        if (out_data.prob_class1 != want.prob_class1)
          report_mismatch("prob_class1", out_data.prob_class1, want.prob_class1);
        if (out_data.prob_class2 != want.prob_class2)
          report_mismatch("prob_class2", out_data.prob_class2, want.prob_class2);
      end
    end
  end

  // Hang detector: reset the count on any beat, either direction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver back-pressure, random while idling is enabled
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Drive one beat: optional gap cycles, then hold until accepted. Entered and
  // left on a falling edge.
  task automatic send_beat(hmsa_in_t b, logic typed, hmsa_out_t res);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    row_typed  = typed;
    row_result = res;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // One frame of random length; a few scores land on the unused class index
  task automatic send_frame(output int sent);
    hmsa_in_t b;
    int       len;
    len = $urandom_range(1, 12);
    for (int j = 0; j < len; j++) begin
      b.class_index = ($urandom_range(99) < 6) ? 2'd3 : CLASS_W'($urandom_range(0, 2));
      case ($urandom_range(3))
        0:       b.score = SCORE_W'($urandom);
        3:       b.score = SCORE_W'($urandom) | 16'h8000;
        default: b.score = SCORE_W'($urandom_range(0, 3584)) - 16'sd512;
      endcase
      b.frame_end = (j == len - 1);
      send_beat(b, 1'b0, '0);
    end
    sent = len;
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frame_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    hmsa_in_t b;
    int       rand_sent;
    int       n;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      b.score       = dir_rows[i].score;
      b.class_index = dir_rows[i].cls;
      b.frame_end   = dir_rows[i].fe;
      send_beat(b, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random frames: first with gaps, then a stretch with none on either side,
    // then a full drain before the gaps come back
    rand_sent = 0;
    while (rand_sent < RAND_BEATS / 3) begin
      send_frame(n);
      rand_sent += n;
    end
    idle_on = 1'b0;
    while (rand_sent < 2 * RAND_BEATS / 3) begin
      send_frame(n);
      rand_sent += n;
    end
    idle_on = 1'b1;
    drain_results();
    while (rand_sent < RAND_BEATS) begin
      send_frame(n);
      rand_sent += n;
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run: %0d score beats in (%0d directed), %0d frame results compared,",
             beats_in, N_DIR, frames_checked);
    $display("     with random gaps, back-pressure, out-of-range classes and a full drain.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
